[hdl/wlvf_pkg.sv]
package wlvf_pkg;

    localparam int MAX_VOTERS = 8;
    localparam int IDX_W      = $clog2(MAX_VOTERS);
    localparam int CNT_W      = $clog2(MAX_VOTERS + 1);
    localparam int LABEL_W    = 16;
    localparam int WEIGHT_W   = 16;
    localparam int DRAW_W     = 16;
    localparam int SUM_W      = 19;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic signed [LABEL_W-1:0] PAD_RESET   = -16'sd1;
    localparam logic signed [LABEL_W-1:0] NO_WINNER   = -16'sd1;
    localparam logic signed [LABEL_W-1:0] EMPTY_LABEL = 16'sd0;

    typedef enum logic [ADDR_W-3:0] {
        REG_PAD_LEVEL = 1'b0
    } wlvf_reg_t;

    typedef struct packed {
        logic signed [LABEL_W-1:0]  label;
        logic signed [WEIGHT_W-1:0] weight;
        logic [DRAW_W-1:0]          tie_draw;
        logic                       last_vote;
    } wlvf_in_t;

    typedef struct packed {
        logic signed [LABEL_W-1:0] fused_label;
        logic                      contended;
        logic                      equivocal;
    } wlvf_out_t;

    // queued vote with its pad classification
    typedef struct packed {
        wlvf_in_t item;
        logic     votes;
    } wlvf_rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MAX,
        ST_TIES,
        ST_INDEX,
        ST_PICK,
        ST_EMIT
    } wlvf_state_t;

endpackage

[hdl/wlvf_front.sv]
module wlvf_front
    import wlvf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [LABEL_W-1:0] pad_level,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  wlvf_in_t                  in_data,
    output logic                      rec_valid,
    output wlvf_rec_t                 rec,
    input  logic                      rec_pop
);

    localparam int QUEUE_DEPTH = 2;

    wlvf_rec_t   mem_reg [QUEUE_DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push;
    logic        pop;
    wlvf_rec_t   new_rec;

    assign in_stall  = (fill_reg == 2'(QUEUE_DEPTH));
    assign push      = in_valid && !in_stall;
    assign rec_valid = (fill_reg != 2'd0);
    assign pop       = rec_pop && rec_valid;
    assign rec       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        new_rec.item  = in_data;
        new_rec.votes = (in_data.label > pad_level);
        wr_ptr_next   = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next   = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next     = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= new_rec;
        end
    end

endmodule

[hdl/wlvf_back.sv]
module wlvf_back
    import wlvf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [LABEL_W-1:0] pad_level,
    input  logic                      rec_valid,
    input  wlvf_rec_t                 rec,
    output logic                      rec_pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output wlvf_out_t                 out_data
);

    wlvf_state_t               state_reg, state_next;
    logic [CNT_W-1:0]          scan_reg, scan_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [LABEL_W-1:0] ref_reg, ref_next;
    logic                      dis_reg, dis_next;
    logic                      first_reg, first_next;
    wlvf_in_t                  cur_reg, cur_next;
    logic signed [SUM_W-1:0]   max_reg, max_next;
    logic signed [LABEL_W-1:0] best_reg, best_next;
    logic [CNT_W-1:0]          ties_reg, ties_next;
    logic [CNT_W-1:0]          pick_reg, pick_next;
    logic signed [LABEL_W-1:0] res_reg, res_next;
    logic                      eq_reg, eq_next;
    logic                      out_valid_reg, out_valid_next;
    wlvf_out_t                 out_reg, out_next;

    logic signed [LABEL_W-1:0] labels_reg [MAX_VOTERS];
    logic signed [SUM_W-1:0]   sums_reg   [MAX_VOTERS];

    logic                      tbl_we;
    logic [IDX_W-1:0]          tbl_waddr;
    logic signed [LABEL_W-1:0] tbl_wlabel;
    logic signed [SUM_W-1:0]   tbl_wsum;

    logic signed [LABEL_W-1:0] e_label;
    logic signed [SUM_W-1:0]   e_sum;
    logic signed [SUM_W:0]     acc;
    logic signed [SUM_W-1:0]   acc_sat;
    logic signed [SUM_W-1:0]   w_ext;
    logic [CNT_W-1:0]          rank;
    logic [DRAW_W+CNT_W:0]     scaled;
    logic                      out_free;

    assign e_label   = labels_reg[scan_reg[IDX_W-1:0]];
    assign e_sum     = sums_reg[scan_reg[IDX_W-1:0]];
    assign w_ext     = SUM_W'(cur_reg.weight);
    assign acc       = (SUM_W+1)'(e_sum) + (SUM_W+1)'(cur_reg.weight);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        if (acc[SUM_W] != acc[SUM_W-1])
        begin
            acc_sat = acc[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            acc_sat = acc[SUM_W-1:0];
        end
    end

    // position of the current entry among the tied entries, by ascending label
    always_comb
    begin
        rank = '0;
        for (int j = 0; j < MAX_VOTERS; j++)
        begin
            if ((CNT_W'(j) < count_reg) && (sums_reg[j] == max_reg) &&
                (labels_reg[j] < e_label))
            begin
                rank = rank + CNT_W'(1);
            end
        end
    end

    // round(draw * (ties - 1)) with the draw in Q0.16
    assign scaled = (DRAW_W+CNT_W+1)'(cur_reg.tie_draw)
                  * (DRAW_W+CNT_W+1)'(ties_reg - CNT_W'(1))
                  + ((DRAW_W+CNT_W+1)'(1) << (DRAW_W - 1));

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        count_next     = count_reg;
        ref_next       = ref_reg;
        dis_next       = dis_reg;
        first_next     = first_reg;
        cur_next       = cur_reg;
        max_next       = max_reg;
        best_next      = best_reg;
        ties_next      = ties_reg;
        pick_next      = pick_reg;
        res_next       = res_reg;
        eq_next        = eq_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        rec_pop        = 1'b0;
        tbl_we         = 1'b0;
        tbl_waddr      = scan_reg[IDX_W-1:0];
        tbl_wlabel     = cur_reg.label;
        tbl_wsum       = acc_sat;

        case (state_reg)
            ST_IDLE:
            begin
                rec_pop = rec_valid;
                if (rec_valid)
                begin
                    cur_next  = rec.item;
                    scan_next = '0;
                    max_next  = '0;
                    best_next = NO_WINNER;
                    if (first_reg)
                    begin
                        ref_next   = rec.item.label;
                        dis_next   = 1'b0;
                        count_next = '0;
                        first_next = 1'b0;
                    end
                    else if ((rec.item.label != ref_reg) &&
                             (rec.votes || (ref_reg > pad_level)))
                    begin
                        dis_next = 1'b1;
                    end
                    if (rec.votes)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else if (rec.item.last_vote)
                    begin
                        state_next = ST_MAX;
                    end
                end
            end

            ST_SEARCH:
            begin
                if ((scan_reg == count_reg) || (e_label == cur_reg.label))
                begin
                    if (scan_reg != count_reg)
                    begin
                        tbl_we = 1'b1;
                    end
                    else if (count_reg < CNT_W'(MAX_VOTERS))
                    begin
                        // new label gets the next free entry; full table drops it
                        tbl_we     = 1'b1;
                        tbl_wsum   = w_ext;
                        count_next = count_reg + CNT_W'(1);
                    end
                    scan_next  = '0;
                    state_next = cur_reg.last_vote ? ST_MAX : ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            ST_MAX:
            begin
                if (!dis_reg)
                begin
                    res_next   = ref_reg;
                    eq_next    = 1'b0;
                    state_next = ST_EMIT;
                end
                else if (count_reg == '0)
                begin
                    res_next   = EMPTY_LABEL;
                    eq_next    = 1'b0;
                    state_next = ST_EMIT;
                end
                else if (scan_reg == count_reg)
                begin
                    scan_next  = '0;
                    ties_next  = '0;
                    state_next = ST_TIES;
                end
                else
                begin
                    if (e_sum > max_reg)
                    begin
                        max_next  = e_sum;
                        best_next = e_label;
                    end
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            ST_TIES:
            begin
                if (scan_reg == count_reg)
                begin
                    state_next = ST_INDEX;
                end
                else
                begin
                    if (e_sum == max_reg)
                    begin
                        ties_next = ties_reg + CNT_W'(1);
                    end
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            ST_INDEX:
            begin
                scan_next = '0;
                if (ties_reg < CNT_W'(2))
                begin
                    res_next   = (max_reg > '0) ? best_reg : NO_WINNER;
                    eq_next    = 1'b0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    eq_next    = 1'b1;
                    pick_next  = scaled[DRAW_W +: CNT_W];
                    state_next = ST_PICK;
                end
            end

            ST_PICK:
            begin
                if (scan_reg == count_reg)
                begin
                    res_next   = EMPTY_LABEL;
                    state_next = ST_EMIT;
                end
                else if ((e_sum == max_reg) && (rank == pick_reg))
                begin
                    res_next   = e_label;
                    state_next = ST_EMIT;
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next.fused_label = res_reg;
                    out_next.contended   = dis_reg;
                    out_next.equivocal   = eq_reg;
                    out_valid_next       = 1'b1;
                    first_next           = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            count_reg     <= '0;
            ref_reg       <= '0;
            dis_reg       <= 1'b0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            count_reg     <= count_next;
            ref_reg       <= ref_next;
            dis_reg       <= dis_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        max_reg  <= max_next;
        best_reg <= best_next;
        ties_reg <= ties_next;
        pick_reg <= pick_next;
        res_reg  <= res_next;
        eq_reg   <= eq_next;
        out_reg  <= out_next;
        if (tbl_we)
        begin
            labels_reg[tbl_waddr] <= tbl_wlabel;
            sums_reg[tbl_waddr]   <= tbl_wsum;
        end
    end

endmodule

[hdl/weighted_label_vote_fusion.sv]
// Fuses the labels of several voters into one label per voxel. Each input
// transaction carries one voter's label and Q4.12 weight; the first vote of a
// voxel is its reference, and the vote marked last_vote yields exactly one
// output transaction. A vote enters a two-entry queue and is then worked on by
// a sequencer that walks the label table one entry per cycle: a vote above
// pad_level goes through a table search and a padding vote skips it. The last
// vote adds the decision: an uncontended voxel yields its reference label, a
// contended one can go through max scan, tie count, draw scaling and tie pick.
// pad_level is written through the APB port at byte address 0 and should only
// change while no voxel is open.
module weighted_label_vote_fusion
    import wlvf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  wlvf_in_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output wlvf_out_t         out_data
);

    logic signed [LABEL_W-1:0] pad_level_reg;
    wlvf_reg_t                 reg_sel;
    logic                      rec_valid;
    wlvf_rec_t                 rec;
    logic                      rec_pop;

    assign pready  = 1'b1;
    assign reg_sel = wlvf_reg_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        case (reg_sel)
            REG_PAD_LEVEL: prdata = DATA_W'(pad_level_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_level_reg <= PAD_RESET;
        end
        else if (psel && penable && pwrite && pready && (reg_sel == REG_PAD_LEVEL))
        begin
            pad_level_reg <= pwdata[LABEL_W-1:0];
        end
    end

    wlvf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pad_level (pad_level_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_pop   (rec_pop)
    );

    wlvf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pad_level (pad_level_reg),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_pop   (rec_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[tb/wlvf_checker.sv]
`timescale 1ns / 1ps

module wlvf_checker
    import wlvf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    input  logic              in_valid,
    input  logic              in_stall,
    input  wlvf_in_t          in_data,
    input  logic              out_valid,
    input  logic              out_stall,
    input  wlvf_out_t         out_data,
    output int                errors,
    output int                pending
);

    logic signed [LABEL_W-1:0] pad_now;
    logic signed [LABEL_W-1:0] ref_label;
    logic                      split_seen;
    logic                      voxel_open;
    logic signed [LABEL_W-1:0] tbl_label [MAX_VOTERS];
    int                        tbl_sum [MAX_VOTERS];
    int                        tbl_used;
    wlvf_out_t                 fused_q [$];

    function automatic int clip_sum(input int s);
        if (s > int'(SUM_MAX))
            return int'(SUM_MAX);
        if (s < int'(SUM_MIN))
            return int'(SUM_MIN);
        return s;
    endfunction

    task automatic add_weight(input logic signed [LABEL_W-1:0] lab,
                              input logic signed [WEIGHT_W-1:0] w);
        for (int i = 0; i < tbl_used; i++)
        begin
            if (tbl_label[i] == lab)
            begin
                tbl_sum[i] = clip_sum(tbl_sum[i] + int'(w));
                return;
            end
        end
        // a new label on a full table loses its weight
        if (tbl_used < MAX_VOTERS)
        begin
            tbl_label[tbl_used] = lab;
            tbl_sum[tbl_used]   = clip_sum(int'(w));
            tbl_used++;
        end
    endtask

    function automatic wlvf_out_t weigh_votes(input logic [DRAW_W-1:0] draw);
        wlvf_out_t                 r;
        int                        peak;
        int                        ties;
        int                        pick;
        int                        rank;
        logic [31:0]               scaled;
        logic signed [LABEL_W-1:0] best;
        r.fused_label = EMPTY_LABEL;
        r.contended   = 1'b1;
        r.equivocal   = 1'b0;
        peak          = 0;
        ties          = 0;
        best          = NO_WINNER;
        if (tbl_used == 0)
            return r;
        for (int i = 0; i < tbl_used; i++)
        begin
            if (tbl_sum[i] > peak)
            begin
                peak = tbl_sum[i];
                best = tbl_label[i];
            end
        end
        for (int i = 0; i < tbl_used; i++)
            if (tbl_sum[i] == peak)
                ties++;
        if (ties < 2)
        begin
            r.fused_label = (peak > 0) ? best : NO_WINNER;
            return r;
        end
        r.equivocal = 1'b1;
        scaled = {16'b0, draw} * 32'(ties - 1) + 32'd32768;
        pick   = int'(scaled >> 16);
        // ties ranked by ascending label
        for (int i = 0; i < tbl_used; i++)
        begin
            if (tbl_sum[i] == peak)
            begin
                rank = 0;
                for (int j = 0; j < tbl_used; j++)
                    if (tbl_sum[j] == peak && tbl_label[j] < tbl_label[i])
                        rank++;
                if (rank == pick)
                begin
                    r.fused_label = tbl_label[i];
                    return r;
                end
            end
        end
        return r;
    endfunction

    task automatic tally_vote(input wlvf_in_t v);
        wlvf_out_t r;
        if (!voxel_open)
        begin
            ref_label  = v.label;
            split_seen = 1'b0;
            tbl_used   = 0;
            voxel_open = 1'b1;
        end
        else if (v.label != ref_label && (v.label > pad_now || ref_label > pad_now))
        begin
            split_seen = 1'b1;
        end
        if (v.label > pad_now)
            add_weight(v.label, v.weight);
        if (v.last_vote)
        begin
            if (split_seen)
                r = weigh_votes(v.tie_draw);
            else
                r = '{fused_label: ref_label, contended: 1'b0, equivocal: 1'b0};
            fused_q.push_back(r);
            voxel_open = 1'b0;
        end
    endtask

    task automatic check_result(input wlvf_out_t got);
        wlvf_out_t want;
        if (fused_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t: unexpected result: label %0d contended %0b equivocal %0b",
                         $realtime, $signed(got.fused_label), got.contended, got.equivocal);
            return;
        end
        want = fused_q.pop_front();
        if (got.fused_label !== want.fused_label || got.contended !== want.contended ||
            got.equivocal !== want.equivocal)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t: mismatch: expected label %0d contended %0b equivocal %0b, %s %0d %0b %0b",
                         $realtime, $signed(want.fused_label), want.contended, want.equivocal,
                         "got", $signed(got.fused_label), got.contended, got.equivocal);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_now    = PAD_RESET;
            ref_label  = '0;
            split_seen = 1'b0;
            voxel_open = 1'b0;
            tbl_used   = 0;
            fused_q.delete();
            errors     = 0;
            pending    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_PAD_LEVEL)
                pad_now = pwdata[LABEL_W-1:0];
            // results first: a vote never yields its result in the same cycle
            if (out_valid && !out_stall)
                check_result(out_data);
            if (in_valid && !in_stall)
                tally_vote(in_data);
            pending = fused_q.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

    import wlvf_pkg::*;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int DRAIN_CYCLES    = 4 * MAX_VOTERS + 20;
    localparam int CYCLE_LIMIT     = 600000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    wlvf_in_t          in_data;
    logic              out_valid;
    logic              out_stall;
    wlvf_out_t         out_data;

    int                        errors;
    int                        pending;
    int                        sent = 0;
    int                        cycles = 0;
    int                        src_idle_pct = 0;
    int                        sink_stall_pct = 0;
    logic signed [LABEL_W-1:0] pad_cur;

    weighted_label_vote_fusion dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    wlvf_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < sink_stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL weighted_label_vote_fusion");
            $finish;
        end
    end

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_vote(input int lab, input int w, input int draw, input bit last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{label: LABEL_W'(lab), weight: WEIGHT_W'(w),
                      tie_draw: DRAW_W'(draw), last_vote: last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    // labels straddling the pad level
    function automatic int near_label();
        int t;
        t = int'(pad_cur) + int'($urandom_range(5)) - 2;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return t;
    endfunction

    function automatic int any16();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    task automatic send_voxel();
        int style;
        int n;
        int lab;
        int w;
        int draw;
        int heavy_w;
        int opts [3];
        bit last;
        style = $urandom_range(99);
        for (int i = 0; i < 3; i++)
            opts[i] = near_label();
        heavy_w = $urandom_range(1) ? 32767 : -32768;
        if (style < 45)
            n = $urandom_range(6, 1);
        else if (style < 70)
            n = $urandom_range(5, 1);
        else if (style < 85)
            n = $urandom_range(10, 1);
        else if (style < 93)
            n = 10;
        else
            n = $urandom_range(12, 1);
        for (int k = 0; k < n; k++)
        begin
            draw = $urandom_range(65535);
            if ($urandom_range(7) == 0)
                draw = $urandom_range(1) ? 65535 : 0;
            last = (k == n - 1);
            if (style < 45)
            begin
                // few labels, coarse weights: exact ties are common
                lab = opts[$urandom_range(2)];
                case ($urandom_range(4))
                    0: w = 4096;
                    1: w = 2048;
                    2: w = -4096;
                    3: w = 0;
                    default: w = 8192;
                endcase
            end
            else if (style < 70)
            begin
                lab = ($urandom_range(4) == 0) ? near_label() : opts[0];
                w   = any16();
            end
            else if (style < 85)
            begin
                lab = $urandom_range(1) ? any16() : near_label();
                w   = any16();
            end
            else if (style < 93)
            begin
                // one label piles up near full scale to reach saturation
                lab = (k == n - 1) ? opts[1] : opts[0];
                w   = (heavy_w > 0) ? heavy_w - int'($urandom_range(100))
                                    : heavy_w + int'($urandom_range(100));
            end
            else
            begin
                lab  = any16();
                w    = any16();
                last = last || ($urandom_range(3) == 0);
            end
            send_vote(lab, w, draw, last);
        end
    endtask

    initial
    begin
        logic signed [LABEL_W-1:0] pad_next;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        in_data  = '0;
        pad_cur  = PAD_RESET;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single voter, real and padding
        send_vote(7, 4096, 0, 1'b1);
        send_vote(-5, 4096, 0, 1'b1);
        // agreement
        send_vote(3, 1000, 0, 1'b0);
        send_vote(3, -1000, 0, 1'b1);
        // unique positive maximum
        send_vote(1, 4096, 0, 1'b0);
        send_vote(2, 8192, 0, 1'b0);
        send_vote(1, 2048, 0, 1'b1);
        // two-way tie, draw at the top of the range
        send_vote(4, 4096, 0, 1'b0);
        send_vote(9, 4096, 65535, 1'b1);
        // no positive sum
        send_vote(5, -32768, 0, 1'b0);
        send_vote(6, -1, 0, 1'b1);
        // lone zero sum against a padding label
        send_vote(5, 0, 0, 1'b0);
        send_vote(-3, 0, 0, 1'b1);
        // table full: the ninth label is dropped, eight-way tie
        for (int i = 1; i <= MAX_VOTERS + 1; i++)
            send_vote(i, 4096, 32768, i == MAX_VOTERS + 1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0: pad_next = 16'sh8000;
                1: pad_next = 16'sh7fff;
                2: pad_next = 16'sh0000;
                3: pad_next = LABEL_W'($urandom_range(65535));
                4: pad_next = PAD_RESET;
                default: pad_next = 16'sd100;
            endcase
            write_reg({REG_PAD_LEVEL, 2'b00}, DATA_W'(int'(pad_next)));
            pad_cur = pad_next;
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 70; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 70; end
                default: begin src_idle_pct = 19; sink_stall_pct = 19; end
            endcase
            while (sent < (ph + 1) * ITEMS_PER_PHASE)
                send_voxel();
        end

        settle();
        if (errors == 0 && pending == 0)
            $display("PASS weighted_label_vote_fusion");
        else
            $display("FAIL weighted_label_vote_fusion");
        $finish;
    end

endmodule
